/* rtl/core/sinosc_pkg.sv */
// ----------------------------------------------------------------------------
// sinosc_pkg
// Shared constants, controller states and the quarter-wave sine table
// generator for the sine oscillator with glide.
// ----------------------------------------------------------------------------
package sinosc_pkg;

   localparam int TABLE_BITS_DEF = 10;
   localparam int MAX_BLOCK_DEF  = 4096;

   localparam int PHASE_W  = 32;
   localparam int STEP_W   = 48;
   localparam int FRAC_W   = 15;
   localparam int GAIN_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = 15;
   localparam int BLEN_W   = 13;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RD,
      ST_MUL,
      ST_DONE
   } osc_state_type;

   // Taylor series of sin(x) in Q30, twelve terms, each product truncated.
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd506; sum = sum - term;
      return sum;
   endfunction

   // Entry k of the quarter wave, sampled at the middle of its interval.
   function automatic logic [ENTRY_W-1:0] quarter_value(input int k, input int tbits);
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] v;
      x = (HALF_PI_Q30 * (64'(2 * k + 1))) >> (tbits + 1);
      s = sin_q30(x);
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[ENTRY_W-1:0];
   endfunction

endpackage

/* rtl/core/sine_oscillator_with_glide.sv */
// ----------------------------------------------------------------------------
// sine_oscillator_with_glide
// Phase-accumulator sine oscillator with a per-block frequency glide.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one sample tick and yields exactly one
// response on the rsp_ channel. req_tuser high opens a block: it loads the
// target step, the gain and the block length. When the target differs from the
// current step, a serial divider works out the per-sample increment and the
// step moves toward the target on each sample, snapping to it on the last one,
// which is flagged by rsp_tlast.
// A plain tick passes the ROM read, the multiply and the round before its
// response. A tick that opens a glide first waits for the one-bit-per-cycle
// 48-bit divider. One tick is worked at a time; a new request is taken as
// soon as the previous response sits in the output register.
// If rsp_tready is low, the finished sample waits in the output register and
// the next tick stalls in its last stage until the register frees up.
// Reset clears phase, step, gain and block state; output is silent (gain zero)
// until the first block start.
// ----------------------------------------------------------------------------
module sine_oscillator_with_glide import sinosc_pkg::*; #(
   parameter int TABLE_BITS = TABLE_BITS_DEF,
   parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // block_len[12:0], target_step[44:13], gain[60:45]
   input  logic        req_tuser,   // block_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample[15:0]
   output logic        rsp_tlast    // block_end
);

   localparam int LEN_W = $clog2(MAX_BLOCK + 1);

   osc_state_type     state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [STEP_W-1:0] cur_ff, cur_in;
   logic [STEP_W-1:0] delta_ff, delta_in;
   logic [PHASE_W-1:0] target_ff, target_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              glide_ff, glide_in;
   logic [STEP_W:0]   diff_ff, diff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [BLEN_W-1:0]  blk_len;
   logic [PHASE_W-1:0] blk_target;
   logic [GAIN_W-1:0]  blk_gain;
   logic [31:0]        len_wide;
   logic [LEN_W-1:0]   len_val;
   logic [STEP_W-1:0]  target_q;
   logic               start_glide;
   logic               rsp_load;
   logic               div_start;
   logic               div_done;
   logic [STEP_W-1:0]  div_quot;
   logic signed [SAMPLE_W-1:0] wave_sample;

   assign blk_len    = req_tdata[12:0];
   assign blk_target = req_tdata[44:13];
   assign blk_gain   = req_tdata[60:45];

   always_comb begin
      len_wide = 32'(blk_len);
      if (len_wide == 32'd0) begin
         len_wide = 32'd1;
      end else if (len_wide > 32'(MAX_BLOCK)) begin
         len_wide = 32'(MAX_BLOCK);
      end
   end

   assign len_val     = len_wide[LEN_W-1:0];
   assign target_q    = {1'b0, blk_target, {FRAC_W{1'b0}}};
   assign start_glide = target_q != cur_ff;

   sinosc_div #(
      .LEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_ff),
      .divisor  (left_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   sinosc_wave #(
      .TABLE_BITS (TABLE_BITS)
   ) u_wave (
      .clock  (clock),
      .phase  (phase_ff),
      .gain   (gain_ff),
      .sample (wave_sample)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      delta_in     = delta_ff;
      target_in    = target_ff;
      gain_in      = gain_ff;
      left_in      = left_ff;
      glide_in     = glide_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_RD;
               if (req_tuser) begin
                  target_in = blk_target;
                  gain_in   = blk_gain;
                  left_in   = len_val;
                  glide_in  = start_glide;
                  if (start_glide) begin
                     state_in = ST_PREP;
                  end
               end
            end
         end
         ST_PREP: begin
            diff_in  = {2'b00, target_ff, {FRAC_W{1'b0}}} - {1'b0, cur_ff};
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               delta_in = div_quot;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // The ROM reads the old phase this cycle; the step moves ahead now.
            if (left_ff != '0 && glide_ff) begin
               cur_in = cur_ff + delta_ff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = wave_sample;
               rsp_last_in  = 1'b0;
               phase_in     = phase_ff + cur_ff[STEP_W-2:FRAC_W];
               if (left_ff != '0) begin
                  left_in = left_ff - 1'b1;
                  if (left_ff == LEN_W'(1)) begin
                     rsp_last_in = 1'b1;
                     glide_in    = 1'b0;
                     if (glide_ff) begin
                        cur_in = {1'b0, target_ff, {FRAC_W{1'b0}}};
                     end
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         cur_ff       <= '0;
         delta_ff     <= '0;
         target_ff    <= '0;
         gain_ff      <= '0;
         left_ff      <= '0;
         glide_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cur_ff       <= cur_in;
         delta_ff     <= delta_in;
         target_ff    <= target_in;
         gain_ff      <= gain_in;
         left_ff      <= left_in;
         glide_ff     <= glide_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A glide only runs inside an open block.
   a_glide_in_block: assert property (@(posedge clock) disable iff (reset)
      glide_ff |-> left_ff != '0)
      else $error("glide active with no samples left");

   // The divider only finishes while the controller waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   // The last sample of a block closes it and is flagged.
   a_block_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && left_ff == LEN_W'(1)) |=> (left_ff == '0 && rsp_tlast && !glide_ff))
      else $error("block end not closed correctly");

endmodule

/* rtl/core/sinosc_div.sv */
// ----------------------------------------------------------------------------
// sinosc_div
// Serial signed divider for the glide increment: one quotient bit per cycle,
// truncation toward zero.
// ----------------------------------------------------------------------------
module sinosc_div import sinosc_pkg::*; #(
   parameter int LEN_W = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [STEP_W:0]   dividend,
   input  logic [LEN_W-1:0]  divisor,
   output logic              done,
   output logic [STEP_W-1:0] quotient
);

   localparam int CNT_W = $clog2(STEP_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEP_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] work_ff, work_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  div_ff, div_in;

   logic [STEP_W:0]   mag;
   logic [LEN_W:0]    shifted;
   logic              fits;

   assign mag     = dividend[STEP_W] ? (~dividend + 1'b1) : dividend;
   assign shifted = {rem_ff, work_ff[STEP_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[STEP_W];
         work_in = mag[STEP_W-1:0];
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[STEP_W-2:0], fits};
         rem_in  = fits ? LEN_W'(shifted - {1'b0, div_ff}) : shifted[LEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~work_ff + 1'b1) : work_ff;

endmodule

/* rtl/core/sinosc_wave.sv */
// ----------------------------------------------------------------------------
// sinosc_wave
// Quarter-wave sine ROM with a registered read, gain multiply and
// round-and-saturate to a signed 16-bit sample.
// ----------------------------------------------------------------------------
module sinosc_wave import sinosc_pkg::*; #(
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic [PHASE_W-1:0]         phase,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int TAB_SIZE = 1 << TABLE_BITS;

   logic [ENTRY_W-1:0] rom_tab [TAB_SIZE];

   for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
      assign rom_tab[k] = quarter_value(k, TABLE_BITS);
   end

   logic [TABLE_BITS-1:0]     idx;
   logic [TABLE_BITS-1:0]     idx_m;
   logic [ENTRY_W-1:0]        rom_ff, rom_in;
   logic                      neg_ff, neg_in;
   logic signed [15:0]        sine;
   logic signed [32:0]        prod_ff, prod_in;
   logic signed [32:0]        rnd;
   logic signed [17:0]        scaled;

   // Quadrants 1 and 3 walk the table backwards.
   assign idx   = phase[PHASE_W-3 -: TABLE_BITS];
   assign idx_m = phase[PHASE_W-2] ? ~idx : idx;

   assign rom_in  = rom_tab[idx_m];
   assign neg_in  = phase[PHASE_W-1];
   assign sine    = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
   assign prod_in = sine * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      rom_ff  <= rom_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign rnd    = prod_ff + 33'sd16384;
   assign scaled = rnd[32:15];

   always_comb begin
      if (scaled > 18'sd32767) begin
         sample = 16'sh7FFF;
      end else if (scaled < -18'sd32768) begin
         sample = 16'sh8000;
      end else begin
         sample = scaled[15:0];
      end
   end

endmodule
